FILE: sv/bhkv_pkg.sv
// Shared types and constants for the bucketed key/value store.
// No dependencies; every other file imports this package.
package bhkv_pkg;

  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;
  localparam int DEF_NUM_BUCKETS  = 16;
  localparam int DEF_BUCKET_DEPTH = 8;

  // one stored entry: value above key
  localparam int ENTRY_W = KEY_W + VALUE_W;

  localparam logic [VALUE_W-1:0] NOT_FOUND_VALUE = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

FILE: sv/bucketed_hash_key_value_store_core.sv
// Top level of the bucketed key/value store: front, queue and back end.
// Depends on bhkv_pkg, bhkv_front, bhkv_queue and bhkv_back.
//
//   channel | valid     | stall     | word
//   command | cmd_valid | cmd_stall | opcode, key, entry_value
//   result  | rsp_valid | rsp_stall | status, found_value
//
// With a power-of-two bucket count the back end sets the sustained rate;
// it takes one item at a time (row read, then compare and write back).
// Otherwise the front end's remainder unit sets it (four bits a cycle,
// then the hand-off) and takes a new command only as the last goes out.
// Synchronous reset clears fill counts and control; rows need no clearing.
// A stalled result holds its register; the queue keeps the front running.
module bucketed_hash_key_value_store_core #(
  parameter int NUM_BUCKETS  = bhkv_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = bhkv_pkg::DEF_BUCKET_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [1:0]                   opcode,
  input  logic [bhkv_pkg::KEY_W-1:0]   key,
  input  logic signed [bhkv_pkg::VALUE_W-1:0] entry_value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic signed [bhkv_pkg::VALUE_W-1:0] found_value
);
  import bhkv_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int QW = 2 + KEY_W + VALUE_W + BW;

  qstat_t             qstat;
  logic               push;
  logic               pop;
  logic [1:0]         push_op;
  logic [KEY_W-1:0]   push_key;
  logic [VALUE_W-1:0] push_val;
  logic [BW-1:0]      push_bucket;
  logic [QW-1:0]      pop_data;

  bhkv_front #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_front (
    .clk, .rst, .cmd_valid, .cmd_stall, .opcode, .key,
    .entry_value(entry_value), .qstat, .push, .push_op, .push_key,
    .push_val, .push_bucket
  );

  bhkv_queue #(.W(QW)) u_queue (
    .clk, .rst, .push,
    .push_data({push_op, push_key, push_val, push_bucket}),
    .pop, .pop_data, .qstat
  );

  bhkv_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .BW(BW)) u_back (
    .clk, .rst, .qstat, .pop,
    .q_op(pop_data[QW-1 -: 2]),
    .q_key(pop_data[QW-3 -: KEY_W]),
    .q_val(pop_data[BW +: VALUE_W]),
    .q_bucket(pop_data[BW-1:0]),
    .rsp_valid, .rsp_stall, .status, .found_value
  );

endmodule

FILE: sv/bhkv_front.sv
// Front end: accepts command words and works out the bucket index.
// Depends on bhkv_pkg.
module bhkv_front #(
  parameter int NUM_BUCKETS = bhkv_pkg::DEF_NUM_BUCKETS,
  parameter int BW = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [1:0]                 opcode,
  input  logic [bhkv_pkg::KEY_W-1:0] key,
  input  logic [bhkv_pkg::VALUE_W-1:0] entry_value,
  input  bhkv_pkg::qstat_t           qstat,
  output logic                       push,
  output logic [1:0]                 push_op,
  output logic [bhkv_pkg::KEY_W-1:0] push_key,
  output logic [bhkv_pkg::VALUE_W-1:0] push_val,
  output logic [BW-1:0]              push_bucket
);
  import bhkv_pkg::*;

  localparam bit POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam int RW = BW + 1;
  localparam logic [RW-1:0] NB = RW'(NUM_BUCKETS);

  logic               hold_valid;
  logic               done;
  logic [1:0]         hold_op;
  logic [KEY_W-1:0]   hold_key;
  logic [VALUE_W-1:0] hold_val;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_next;
  logic [2:0]         cnt;
  logic [31:0]        keyp;
  logic               accept;

  assign push      = hold_valid && done && !qstat.full;
  assign cmd_stall = hold_valid && !push;
  assign accept    = cmd_valid && !cmd_stall;
  assign keyp      = {1'b0, hold_key};

  // four restoring remainder steps per cycle, MSB first
  always_comb begin
    rem_next = rem;
    for (int s = 0; s < 4; s++) begin
      rem_next = {rem_next[RW-2:0], keyp[5'(31 - (int'(cnt) * 4 + s))]};
      if (rem_next >= NB) begin
        rem_next = rem_next - NB;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      done       <= 1'b0;
      cnt        <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
        done       <= POW2;
        cnt        <= '0;
      end else begin
        if (push) begin
          hold_valid <= 1'b0;
        end
        if (hold_valid && !done) begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            done <= 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op  <= opcode;
      hold_key <= key;
      hold_val <= entry_value;
      rem      <= '0;
    end else if (hold_valid && !done) begin
      rem <= rem_next;
    end
  end

  assign push_op  = hold_op;
  assign push_key = hold_key;
  assign push_val = hold_val;

  generate
    if (POW2) begin : g_mask
      logic [KEY_W-1:0] masked;
      assign masked      = hold_key & KEY_W'(NUM_BUCKETS - 1);
      assign push_bucket = masked[BW-1:0];
    end else begin : g_rem
      assign push_bucket = rem[BW-1:0];
    end
  endgenerate

endmodule

FILE: sv/bhkv_queue.sv
// Two-word queue between the front and back ends.
// Depends on bhkv_pkg.
module bhkv_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     pop_data,
  output bhkv_pkg::qstat_t qstat
);
  import bhkv_pkg::*;

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data    = slots[rd_ptr];
  assign qstat.valid = count != 2'd0;
  assign qstat.full  = count == 2'd2;

endmodule

FILE: sv/bhkv_back.sv
// Back end: bucket row memory, fill counts, read-modify-write and result word.
// Depends on bhkv_pkg.
module bhkv_back #(
  parameter int NUM_BUCKETS  = bhkv_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = bhkv_pkg::DEF_BUCKET_DEPTH,
  parameter int BW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bhkv_pkg::qstat_t             qstat,
  output logic                         pop,
  input  logic [1:0]                   q_op,
  input  logic [bhkv_pkg::KEY_W-1:0]   q_key,
  input  logic [bhkv_pkg::VALUE_W-1:0] q_val,
  input  logic [BW-1:0]                q_bucket,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic [bhkv_pkg::VALUE_W-1:0] found_value
);
  import bhkv_pkg::*;

  localparam int D    = BUCKET_DEPTH;
  localparam int FW   = $clog2(D + 1);
  localparam int IW   = (D > 1) ? $clog2(D) : 1;
  localparam int ROWW = D * ENTRY_W;

  back_state_t state, state_next;
  logic exec;

  logic [ROWW-1:0]    mem [NUM_BUCKETS];
  logic [FW-1:0]      fill [NUM_BUCKETS];
  logic [ROWW-1:0]    row_rd;
  logic [FW-1:0]      fill_q;
  logic [1:0]         op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic [BW-1:0]      bucket_q;

  logic [D-1:0]       match;
  logic [D-1:0]       first;
  logic [D-1:0]       ge;
  logic               hit;
  logic               full;
  logic [VALUE_W-1:0] sel_val;
  logic [ROWW-1:0]    row_new;
  logic [FW-1:0]      fill_new;
  logic [1:0]         status_new;
  logic [VALUE_W-1:0] value_new;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (pop) state_next = BK_EXEC;
      BK_EXEC: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // state outputs: take a word only when the result register will be free
  always_comb begin
    pop  = 1'b0;
    exec = 1'b0;
    case (state)
      BK_IDLE: pop = qstat.valid && (!rsp_valid || !rsp_stall);
      BK_EXEC: exec = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row read, registered
  always_ff @(posedge clk) begin
    if (pop) begin
      row_rd   <= mem[q_bucket];
      fill_q   <= fill[q_bucket];
      op_q     <= q_op;
      key_q    <= q_key;
      val_q    <= q_val;
      bucket_q <= q_bucket;
    end
  end

  // compare all live entries of the row in parallel
  always_comb begin
    sel_val = '0;
    for (int j = 0; j < D; j++) begin
      match[j] = (FW'(j) < fill_q) && (row_rd[j*ENTRY_W +: KEY_W] == key_q);
    end
    first = match & (~match + D'(1));
    ge    = ~(first - D'(1));
    hit   = |match;
    full  = fill_q >= FW'(D);
    for (int j = 0; j < D; j++) begin
      if (first[j]) begin
        sel_val = sel_val | row_rd[j*ENTRY_W + KEY_W +: VALUE_W];
      end
    end
  end

  // new row, fill and result
  always_comb begin
    row_new    = row_rd;
    fill_new   = fill_q;
    status_new = ST_DONE;
    value_new  = NOT_FOUND_VALUE;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          status_new = ST_FULL;
        end else begin
          row_new[fill_q[IW-1:0]*ENTRY_W +: ENTRY_W] = {val_q, key_q};
          fill_new = fill_q + FW'(1);
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          value_new = sel_val;
        end else begin
          status_new = ST_MISS;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          for (int j = 0; j < D - 1; j++) begin
            if (ge[j]) begin
              row_new[j*ENTRY_W +: ENTRY_W] = row_rd[(j+1)*ENTRY_W +: ENTRY_W];
            end
          end
          fill_new = fill_q - FW'(1);
        end else begin
          status_new = ST_MISS;
        end
      end
      default: ;
    endcase
  end

  // row write back
  always_ff @(posedge clk) begin
    if (exec) begin
      mem[bucket_q] <= row_new;
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill[b] <= '0;
      end
    end else if (exec) begin
      fill[bucket_q] <= fill_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status      <= status_new;
      found_value <= value_new;
    end
  end

endmodule

FILE: sv/bhkv_checker.sv
// Port-level checks on the key/value store, bound to the top level.
// Depends on bhkv_pkg.
module bhkv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [1:0]                   status,
  input logic [bhkv_pkg::VALUE_W-1:0] found_value
);
  import bhkv_pkg::*;

  // no result word comes straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // a miss or full result carries the not-found value
  a_value_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_DONE) |-> found_value == NOT_FOUND_VALUE)
    else $error("value on a miss or full status");

  // status is never the unused code
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_DONE || status == ST_MISS || status == ST_FULL))
    else $error("bad status code");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(found_value)))
    else $error("stalled result changed");

endmodule

bind bucketed_hash_key_value_store_core bhkv_checker u_checker (
  .clk, .rst, .rsp_valid, .rsp_stall, .status, .found_value
);

FILE: sim/testbench.sv
// Testbench for bucketed_hash_key_value_store_core: directed and random command words.
// Depends on bhkv_pkg and the core RTL; results are checked against an in-bench table model.
`timescale 1ns / 100ps

module testbench;
  import bhkv_pkg::*;

  localparam int NB = DEF_NUM_BUCKETS;
  localparam int BD = DEF_BUCKET_DEPTH;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [1:0] opcode = OP_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic signed [VALUE_W-1:0] entry_value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [1:0] status;
  logic signed [VALUE_W-1:0] found_value;

  bucketed_hash_key_value_store_core u_top (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .opcode(opcode), .key(key), .entry_value(entry_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .found_value(found_value)
  );

  always #10 clk = ~clk;

  // shadow copy of the table
  logic [KEY_W-1:0]   tbl_key [NB][BD];
  logic [VALUE_W-1:0] tbl_val [NB][BD];
  int                 tbl_fill [NB];

  typedef struct packed {
    logic [1:0]         st;
    logic [VALUE_W-1:0] val;
  } outcome_t;

  outcome_t pending_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int burst_left = 0;
  int hot_keys[$];

  // compute the outcome of one command and update the shadow table
  function automatic outcome_t apply_cmd(logic [1:0] op, logic [KEY_W-1:0] k,
                                         logic [VALUE_W-1:0] v);
    outcome_t o;
    int b;
    int hit;
    b = k % NB;
    o.st = ST_DONE;
    o.val = NOT_FOUND_VALUE;
    hit = -1;
    for (int i = 0; i < tbl_fill[b]; i++)
      if (hit < 0 && tbl_key[b][i] == k) hit = i;
    if (op == OP_INSERT) begin
      if (tbl_fill[b] >= BD) begin
        o.st = ST_FULL;
      end else begin
        tbl_key[b][tbl_fill[b]] = k;
        tbl_val[b][tbl_fill[b]] = v;
        tbl_fill[b]++;
      end
    end else if (op == OP_SEARCH) begin
      if (hit < 0) o.st = ST_MISS;
      else o.val = tbl_val[b][hit];
    end else if (op == OP_DELETE) begin
      if (hit < 0) begin
        o.st = ST_MISS;
      end else begin
        for (int i = hit; i + 1 < tbl_fill[b]; i++) begin
          tbl_key[b][i] = tbl_key[b][i+1];
          tbl_val[b][i] = tbl_val[b][i+1];
        end
        tbl_fill[b]--;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  // send one command word; bursts with random gaps
  task automatic send_word(logic [1:0] op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pending_q.push_back(apply_cmd(op, k, v));
    cmd_valid <= 1'b1;
    opcode <= op;
    key <= k;
    entry_value <= v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drop_valid();
    cmd_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain();
    drop_valid();
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiver stall pattern: runs of stall and free cycles, sometimes none
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else if ((words_sent / 200) % 3 == 1) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(0, 99) < 35);
  end

  // result checker
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", status, 0);
      end else begin
        w = pending_q.pop_front();
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (found_value !== w.val) report_mismatch("found_value", found_value, w.val);
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (hot_keys.size() != 0 && $urandom_range(0, 99) < 60)
      return KEY_W'(hot_keys[$urandom_range(0, hot_keys.size() - 1)]);
    // mostly keys 0 to 63, few per bucket, to hit full and deep chains
    k = $urandom_range(0, 99) < 30 ? KEY_W'($urandom()) : KEY_W'($urandom_range(0, 63));
    if (hot_keys.size() < 24) hot_keys.push_back(k);
    return k;
  endfunction

  // directed corners: extremes, every operation, full bucket, misses, duplicates
  task automatic test_directed();
    send_word(OP_SEARCH, 5, 0);
    send_word(OP_DELETE, 5, 0);
    send_word(OP_INSERT, '1, 32'h7FFF_FFFF);
    send_word(OP_INSERT, 0, 32'h8000_0000);
    send_word(OP_SEARCH, '1, 0);
    send_word(OP_SEARCH, 0, 0);
    for (int i = 0; i < BD; i++)
      send_word(OP_INSERT, KEY_W'(3 + 16 * (i % 2)), VALUE_W'(100 + i));
    send_word(OP_INSERT, 35, 1);
    send_word(OP_SEARCH, 19, 0);
    send_word(OP_DELETE, 3, 0);
    send_word(OP_SEARCH, 3, 0);
    send_word(OP_INSERT, 35, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 35, 0);
    send_word(2'd3, 3, 0);
    send_word(OP_DELETE, '1, 0);
    drain();
  endtask

  // random mix of well-formed traffic and illegal opcodes
  task automatic test_random(int n);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      op = r < 45 ? OP_INSERT : r < 75 ? OP_SEARCH : r < 97 ? OP_DELETE : 2'd3;
      send_word(op, pick_key(), $urandom());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    for (int b = 0; b < NB; b++) tbl_fill[b] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1100);
    $display("Sent %0d command words, checked %0d results,", words_sent, results_seen);
    $display("covering full buckets, misses, duplicate keys and random stalls.");
    if (errors == 0 && pending_q.size() == 0)
      $display("bucketed_hash_key_value_store_core test passed");
    else
      $display("bucketed_hash_key_value_store_core test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("bucketed_hash_key_value_store_core test failed");
    $finish;
  end

endmodule

FILE: files.f
sv/bhkv_pkg.sv
sv/bhkv_front.sv
sv/bhkv_queue.sv
sv/bhkv_back.sv
sv/bucketed_hash_key_value_store_core.sv
sv/bhkv_checker.sv
sim/testbench.sv
